@@ hdl/adjacency_matrix_graph_store_top_assert.svh @@
// ----------------------------------------------------------------------------
// assertion macros for the graph store top level
// ----------------------------------------------------------------------------
`ifndef ADJACENCY_MATRIX_GRAPH_STORE_TOP_ASSERT_SVH
`define ADJACENCY_MATRIX_GRAPH_STORE_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define AMG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define AMG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/amg_pkg.sv @@
// ----------------------------------------------------------------------------
// amg_pkg
// types and constants shared by the graph store and its channel interfaces
// ----------------------------------------------------------------------------
package amg_pkg;

    // fixed field widths of the request and response channels
    localparam int KIND_W    = 3;
    localparam int KEY_W     = 32;
    localparam int WEIGHT_W  = 16;
    localparam int STATUS_W  = 2;

    // weight value meaning no edge
    localparam int NO_EDGE = 0;

    // operation codes
    typedef enum logic [KIND_W-1:0] {
        KIND_ADD_VERTEX  = 3'd0,
        KIND_ADD_EDGE    = 3'd1,
        KIND_LIST        = 3'd2,
        KIND_CLEAR_MARKS = 3'd3,
        KIND_MARK        = 3'd4,
        KIND_IS_MARKED   = 3'd5
    } t_kind;

    // response status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_SEARCH,
        S_LIST,
        S_LEND,
        S_RESP
    } t_state;

endpackage

@@ hdl/amg_req_if.sv @@
// ----------------------------------------------------------------------------
// amg_req_if
// request channel: one graph operation per request
// ----------------------------------------------------------------------------
interface amg_req_if;
    import amg_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [KIND_W-1:0]          kind;
    logic [KEY_W-1:0]           vertex_key;
    logic [KEY_W-1:0]           target_key;
    logic signed [WEIGHT_W-1:0] edge_weight;

    modport source (output valid, kind, vertex_key, target_key, edge_weight, input ready);
    modport sink   (input valid, kind, vertex_key, target_key, edge_weight, output ready);
endinterface

@@ hdl/amg_rsp_if.sv @@
// ----------------------------------------------------------------------------
// amg_rsp_if
// response channel: one or more results per request
// ----------------------------------------------------------------------------
interface amg_rsp_if;
    import amg_pkg::*;

    logic                valid;
    logic                ready;
    logic [KEY_W-1:0]    neighbour_key;
    logic                is_marked_flag;
    logic                has_neighbour;
    logic [STATUS_W-1:0] status;
    logic                last_result;

    modport source (output valid, neighbour_key, is_marked_flag, has_neighbour, status,
                    last_result, input ready);
    modport sink   (input valid, neighbour_key, is_marked_flag, has_neighbour, status,
                    last_result, output ready);
endinterface

@@ hdl/adjacency_matrix_graph_store_top.sv @@
// add vertex writes the key, then clears the new row and column; key lookups scan one slot a cycle
// add edge runs two lookups; listing reads one matrix entry a cycle over the n stored vertices,
// unless the response channel stalls; one request at a time, as requests are taken only when idle
// results are registered; the next request can be taken in the cycle after the last result is loaded
// reset clears vertex count, marks and control state; the matrix needs no sweep
// since add vertex clears the new row and column before any entry of it is read
// ----------------------------------------------------------------------------
// adjacency_matrix_graph_store_top
// weighted directed graph held in a key memory and an adjacency matrix memory
// ----------------------------------------------------------------------------
module adjacency_matrix_graph_store_top #(
    parameter int MAX_VERTICES = 8,
    parameter int KEY_BITS     = 32,
    parameter int WEIGHT_BITS  = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    amg_req_if.sink    i_req,
    amg_rsp_if.source  o_rsp
);
    import amg_pkg::*;

    localparam int VB = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CB = $clog2(MAX_VERTICES + 1);
    localparam int IW = CB + 1;
    localparam int ED = MAX_VERTICES * MAX_VERTICES;
    localparam int AW = $clog2(ED);

    // memories
    logic [KEY_BITS-1:0]    mem_keys  [MAX_VERTICES];
    logic [WEIGHT_BITS-1:0] mem_edges [ED];
    logic [KEY_BITS-1:0]    r_key_rd;
    logic [WEIGHT_BITS-1:0] r_edge_rd;

    logic                   key_we, key_re;
    logic [VB-1:0]          key_wa, key_ra;
    logic [KEY_BITS-1:0]    key_wd;
    logic                   edge_we, edge_re;
    logic [AW-1:0]          edge_wa, edge_ra;
    logic [WEIGHT_BITS-1:0] edge_wd;

    // control registers
    t_state                r_state, n_state;
    logic [CB-1:0]         r_count, n_count;
    logic [IW-1:0]         r_idx, n_idx;
    logic                  r_pend, n_pend;
    logic [VB-1:0]         r_pend_idx, n_pend_idx;
    logic                  r_phase, n_phase;
    logic [VB-1:0]         r_a, n_a;
    logic [MAX_VERTICES-1:0] r_marks, n_marks;
    logic                  r_hold_valid, n_hold_valid;
    logic [KEY_BITS-1:0]   r_hold_key, n_hold_key;
    t_status               r_resp_status, n_resp_status;
    logic                  r_resp_flag, n_resp_flag;

    // request payload
    logic [KIND_W-1:0]          r_kind;
    logic [KEY_W-1:0]           r_vkey, r_tkey;
    logic signed [WEIGHT_W-1:0] r_weight;

    // output register
    logic                r_out_valid, n_out_valid;
    logic [KEY_W-1:0]    r_out_key, n_out_key;
    logic                r_out_flag, n_out_flag;
    logic                r_out_has, n_out_has;
    t_status             r_out_status, n_out_status;
    logic                r_out_last, n_out_last;

    logic                accept;
    logic                out_free;
    logic [KEY_BITS-1:0] skey;
    logic                match;
    logic                nz;
    logic                stall;
    logic [VB-1:0]       slot;
    logic [VB-1:0]       clr_j;

    assign accept   = i_req.valid && i_req.ready;
    assign out_free = !r_out_valid || o_rsp.ready;
    assign skey     = KEY_BITS'(r_phase ? r_tkey : r_vkey);
    assign match    = r_pend && (r_key_rd == skey);
    assign nz       = r_pend && (r_edge_rd != WEIGHT_BITS'(NO_EDGE));
    assign stall    = nz && r_hold_valid && !out_free;
    assign slot     = VB'(r_count);
    assign clr_j    = (r_idx < IW'(MAX_VERTICES)) ? VB'(r_idx)
                                                 : VB'(r_idx - IW'(MAX_VERTICES));

    assign i_req.ready          = (r_state == S_IDLE);
    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.neighbour_key  = r_out_key;
    assign o_rsp.is_marked_flag = r_out_flag;
    assign o_rsp.has_neighbour  = r_out_has;
    assign o_rsp.status         = r_out_status;
    assign o_rsp.last_result    = r_out_last;

    // key memory, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (key_we) begin
            mem_keys[key_wa] <= key_wd;
        end
        if (key_re) begin
            r_key_rd <= mem_keys[key_ra];
        end
    end

    // adjacency matrix memory, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (edge_we) begin
            mem_edges[edge_wa] <= edge_wd;
        end
        if (edge_re) begin
            r_edge_rd <= mem_edges[edge_ra];
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind   <= i_req.kind;
            r_vkey   <= i_req.vertex_key;
            r_tkey   <= i_req.target_key;
            r_weight <= i_req.edge_weight;
        end
    end

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_idx        <= '0;
            r_pend       <= 1'b0;
            r_phase      <= 1'b0;
            r_marks      <= '0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_idx        <= n_idx;
            r_pend       <= n_pend;
            r_phase      <= n_phase;
            r_marks      <= n_marks;
            r_hold_valid <= n_hold_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pend_idx    <= n_pend_idx;
        r_a           <= n_a;
        r_hold_key    <= n_hold_key;
        r_resp_status <= n_resp_status;
        r_resp_flag   <= n_resp_flag;
        r_out_key     <= n_out_key;
        r_out_flag    <= n_out_flag;
        r_out_has     <= n_out_has;
        r_out_status  <= n_out_status;
        r_out_last    <= n_out_last;
    end

    // sequencer
    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_idx         = r_idx;
        n_pend        = r_pend;
        n_pend_idx    = r_pend_idx;
        n_phase       = r_phase;
        n_a           = r_a;
        n_marks       = r_marks;
        n_hold_valid  = r_hold_valid;
        n_hold_key    = r_hold_key;
        n_resp_status = r_resp_status;
        n_resp_flag   = r_resp_flag;

        n_out_valid   = r_out_valid && !o_rsp.ready;
        n_out_key     = r_out_key;
        n_out_flag    = r_out_flag;
        n_out_has     = r_out_has;
        n_out_status  = r_out_status;
        n_out_last    = r_out_last;

        key_we  = 1'b0;
        key_wa  = slot;
        key_wd  = KEY_BITS'(i_req.vertex_key);
        key_re  = 1'b0;
        key_ra  = VB'(r_idx);
        edge_we = 1'b0;
        edge_wa = '0;
        edge_wd = '0;
        edge_re = 1'b0;
        edge_ra = AW'(r_a) * AW'(MAX_VERTICES) + AW'(VB'(r_idx));

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_resp_status = ST_OK;
                    n_resp_flag   = 1'b0;
                    n_idx         = '0;
                    n_pend        = 1'b0;
                    n_phase       = 1'b0;
                    unique case (i_req.kind)
                        KIND_ADD_VERTEX: begin
                            if (r_count == CB'(MAX_VERTICES)) begin
                                n_resp_status = ST_FULL;
                                n_state       = S_RESP;
                            end else begin
                                key_we  = 1'b1;
                                n_state = S_CLEAR;
                            end
                        end
                        KIND_ADD_EDGE, KIND_LIST, KIND_MARK, KIND_IS_MARKED: begin
                            if (r_count == '0) begin
                                n_resp_status = ST_NOT_FOUND;
                                n_state       = S_RESP;
                            end else begin
                                n_state = S_SEARCH;
                            end
                        end
                        KIND_CLEAR_MARKS: begin
                            n_marks = '0;
                            n_state = S_RESP;
                        end
                        default: begin
                            n_state = S_RESP;
                        end
                    endcase
                end
            end

            // clear the new row, then the new column, one entry a cycle
            S_CLEAR: begin
                edge_we = 1'b1;
                if (r_idx < IW'(MAX_VERTICES)) begin
                    edge_wa = AW'(slot) * AW'(MAX_VERTICES) + AW'(clr_j);
                end else begin
                    edge_wa = AW'(clr_j) * AW'(MAX_VERTICES) + AW'(slot);
                end
                if (r_idx == IW'(2 * MAX_VERTICES - 1)) begin
                    n_count = r_count + CB'(1);
                    n_state = S_RESP;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end

            // key lookup: read one slot a cycle, compare it the cycle after
            S_SEARCH: begin
                if (match) begin
                    n_idx  = '0;
                    n_pend = 1'b0;
                    priority case (r_kind)
                        KIND_ADD_EDGE: begin
                            if (!r_phase) begin
                                n_a     = r_pend_idx;
                                n_phase = 1'b1;
                            end else begin
                                edge_we = 1'b1;
                                edge_wa = AW'(r_a) * AW'(MAX_VERTICES) + AW'(r_pend_idx);
                                edge_wd = WEIGHT_BITS'(r_weight);
                                n_state = S_RESP;
                            end
                        end
                        KIND_LIST: begin
                            n_a          = r_pend_idx;
                            n_hold_valid = 1'b0;
                            n_state      = S_LIST;
                        end
                        KIND_MARK: begin
                            n_marks[r_pend_idx] = 1'b1;
                            n_state             = S_RESP;
                        end
                        KIND_IS_MARKED: begin
                            n_resp_flag = r_marks[r_pend_idx];
                            n_state     = S_RESP;
                        end
                        default: begin
                            n_state = S_RESP;
                        end
                    endcase
                end else if (r_idx < IW'(r_count)) begin
                    key_re     = 1'b1;
                    n_pend     = 1'b1;
                    n_pend_idx = VB'(r_idx);
                    n_idx      = r_idx + IW'(1);
                end else begin
                    n_pend        = 1'b0;
                    n_resp_status = ST_NOT_FOUND;
                    n_state       = S_RESP;
                end
            end

            // row scan; each successor is held until the next one shows it is not last
            S_LIST: begin
                if (!stall) begin
                    if (nz) begin
                        if (r_hold_valid) begin
                            n_out_valid  = 1'b1;
                            n_out_key    = KEY_W'(r_hold_key);
                            n_out_flag   = 1'b0;
                            n_out_has    = 1'b1;
                            n_out_status = ST_OK;
                            n_out_last   = 1'b0;
                        end
                        n_hold_key   = r_key_rd;
                        n_hold_valid = 1'b1;
                    end
                    if (r_idx < IW'(r_count)) begin
                        key_re  = 1'b1;
                        edge_re = 1'b1;
                        n_pend  = 1'b1;
                        n_idx   = r_idx + IW'(1);
                    end else begin
                        n_pend  = 1'b0;
                        n_state = S_LEND;
                    end
                end
            end

            // final listing result, or the empty one
            S_LEND: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_key    = r_hold_valid ? KEY_W'(r_hold_key) : '0;
                    n_out_flag   = 1'b0;
                    n_out_has    = r_hold_valid;
                    n_out_status = ST_OK;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end

            // single result of every other request, and of a listing whose source key is not found
            S_RESP: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_key    = '0;
                    n_out_flag   = r_resp_flag;
                    n_out_has    = 1'b0;
                    n_out_status = r_resp_status;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // checks on the sequencer
`include "adjacency_matrix_graph_store_top_assert.svh"

    `AMG_ASSERT_NOW(a_list_source_stored, i_clk, i_rst_n, (r_state == S_LIST),
        (CB'(r_a) < r_count), "listing source slot beyond vertex count")
    `AMG_ASSERT_NOW(a_search_slot_stored, i_clk, i_rst_n, (r_state == S_SEARCH && r_pend),
        (CB'(r_pend_idx) < r_count), "key compare on a slot beyond vertex count")
    `AMG_ASSERT_NEXT(a_count_only_after_clear, i_clk, i_rst_n,
        (r_state != S_CLEAR), $stable(r_count), "vertex count moved outside clear sweep")

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// checks the graph store against its own copy of the key table, matrix and
// marks: directed corner cases first, then randomised graph traffic with
// idle gaps on both channels and one long response back-pressure stretch
// ----------------------------------------------------------------------------
module tb_top;
    import amg_pkg::*;

    localparam int MAX_VERT = 8;

    // spare operation codes that the store must ignore
    localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd7;

    typedef struct packed {
        logic [KIND_W-1:0]          kind;
        logic [KEY_W-1:0]           vertex_key;
        logic [KEY_W-1:0]           target_key;
        logic signed [WEIGHT_W-1:0] edge_weight;
    } t_graph_op;

    typedef struct packed {
        logic [KEY_W-1:0]    neighbour_key;
        logic                is_marked_flag;
        logic                has_neighbour;
        logic [STATUS_W-1:0] status;
        logic                last_result;
    } t_graph_result;

    logic clk = 1'b0;
    logic rst_n;

    amg_req_if req_ch ();
    amg_rsp_if rsp_ch ();

    adjacency_matrix_graph_store_top #(
        .MAX_VERTICES (MAX_VERT),
        .KEY_BITS     (KEY_W),
        .WEIGHT_BITS  (WEIGHT_W)
    ) u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // clock
    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // requests waiting to be offered and results due back
    t_graph_op     graph_ops_queued [$];
    t_graph_result graph_results_due [$];
    logic [KEY_W-1:0] gen_keys [$];

    // shadow graph
    logic [KEY_W-1:0]           vert_keys  [MAX_VERT];
    int                         vert_count = 0;
    logic signed [WEIGHT_W-1:0] edge_w     [MAX_VERT*MAX_VERT] = '{default: '0};
    logic                       marks      [MAX_VERT] = '{default: 1'b0};

    int   ops_taken = 0;
    int   errors = 0;
    int   stall_left = 0;
    logic stall_done = 1'b0;
    logic quiet;

    // no idling on either side over a stretch of the run
    assign quiet = (ops_taken >= 150) && (ops_taken < 230);

    function automatic int find_key(logic [KEY_W-1:0] key);
        for (int i = 0; i < vert_count; i++)
            if (vert_keys[i] == key) return i;
        return -1;
    endfunction

    function automatic void due_result(logic [KEY_W-1:0] key, logic flag, logic has,
                                       t_status st, logic last);
        t_graph_result r;
        r.neighbour_key  = key;
        r.is_marked_flag = flag;
        r.has_neighbour  = has;
        r.status         = st;
        r.last_result    = last;
        graph_results_due.push_back(r);
    endfunction

    // apply one request to the shadow graph and queue the results it causes
    function automatic void apply_graph_op(t_graph_op op);
        int src;
        int dst;
        int hits;
        int seen;
        src = find_key(op.vertex_key);
        dst = find_key(op.target_key);
        hits = 0;
        seen = 0;
        case (op.kind)
            KIND_ADD_VERTEX: begin
                if (vert_count >= MAX_VERT) begin
                    due_result('0, 1'b0, 1'b0, ST_FULL, 1'b1);
                end else begin
                    vert_keys[vert_count] = op.vertex_key;
                    for (int i = 0; i < MAX_VERT; i++) begin
                        edge_w[vert_count*MAX_VERT+i] = WEIGHT_W'(NO_EDGE);
                        edge_w[i*MAX_VERT+vert_count] = WEIGHT_W'(NO_EDGE);
                    end
                    vert_count++;
                    due_result('0, 1'b0, 1'b0, ST_OK, 1'b1);
                end
            end
            KIND_ADD_EDGE: begin
                if (src < 0 || dst < 0) begin
                    due_result('0, 1'b0, 1'b0, ST_NOT_FOUND, 1'b1);
                end else begin
                    edge_w[src*MAX_VERT+dst] = op.edge_weight;
                    due_result('0, 1'b0, 1'b0, ST_OK, 1'b1);
                end
            end
            KIND_LIST: begin
                if (src < 0) begin
                    due_result('0, 1'b0, 1'b0, ST_NOT_FOUND, 1'b1);
                end else begin
                    for (int i = 0; i < vert_count; i++)
                        if (edge_w[src*MAX_VERT+i] != WEIGHT_W'(NO_EDGE)) hits++;
                    if (hits == 0) begin
                        due_result('0, 1'b0, 1'b0, ST_OK, 1'b1);
                    end else begin
                        for (int i = 0; i < vert_count; i++) begin
                            if (edge_w[src*MAX_VERT+i] != WEIGHT_W'(NO_EDGE)) begin
                                seen++;
                                due_result(vert_keys[i], 1'b0, 1'b1, ST_OK, seen == hits);
                            end
                        end
                    end
                end
            end
            KIND_CLEAR_MARKS: begin
                for (int i = 0; i < MAX_VERT; i++) marks[i] = 1'b0;
                due_result('0, 1'b0, 1'b0, ST_OK, 1'b1);
            end
            KIND_MARK: begin
                if (src < 0) begin
                    due_result('0, 1'b0, 1'b0, ST_NOT_FOUND, 1'b1);
                end else begin
                    marks[src] = 1'b1;
                    due_result('0, 1'b0, 1'b0, ST_OK, 1'b1);
                end
            end
            KIND_IS_MARKED: begin
                if (src < 0) due_result('0, 1'b0, 1'b0, ST_NOT_FOUND, 1'b1);
                else due_result('0, marks[src], 1'b0, ST_OK, 1'b1);
            end
            default: begin
                due_result('0, 1'b0, 1'b0, ST_OK, 1'b1);
            end
        endcase
    endfunction

    // stimulus helpers
    function automatic void queue_op(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] vkey,
                                     logic [KEY_W-1:0] tkey, logic [WEIGHT_W-1:0] w);
        t_graph_op op;
        op.kind        = kind;
        op.vertex_key  = vkey;
        op.target_key  = tkey;
        op.edge_weight = w;
        graph_ops_queued.push_back(op);
        if (kind == KIND_ADD_VERTEX && gen_keys.size() < MAX_VERT) gen_keys.push_back(vkey);
    endfunction

    // mostly a key of an earlier add vertex request, sometimes a random one
    function automatic logic [KEY_W-1:0] pick_key();
        if (gen_keys.size() > 0 && $urandom_range(0, 99) < 85)
            return gen_keys[$urandom_range(0, gen_keys.size() - 1)];
        return $urandom;
    endfunction

    function automatic logic [WEIGHT_W-1:0] rand_weight();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return '0;
        if (r < 15) return 16'h8000;
        if (r < 20) return 16'h7fff;
        if (r < 25) return 16'hffff;
        return WEIGHT_W'($urandom);
    endfunction

    // request driver
    t_graph_op offered;
    always @(posedge clk) begin
        if (!rst_n) begin
            req_ch.valid       <= 1'b0;
            req_ch.kind        <= '0;
            req_ch.vertex_key  <= '0;
            req_ch.target_key  <= '0;
            req_ch.edge_weight <= '0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                apply_graph_op(offered);
                ops_taken <= ops_taken + 1;
            end
            if (!req_ch.valid || req_ch.ready) begin
                if (graph_ops_queued.size() > 0 && (quiet || $urandom_range(0, 99) >= 32)) begin
                    offered = graph_ops_queued.pop_front();
                    req_ch.valid       <= 1'b1;
                    req_ch.kind        <= offered.kind;
                    req_ch.vertex_key  <= offered.vertex_key;
                    req_ch.target_key  <= offered.target_key;
                    req_ch.edge_weight <= offered.edge_weight;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // response monitor and ready generation
    t_graph_result want;
    always @(posedge clk) begin
        if (!rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (graph_results_due.size() == 0) begin
                    $error("response with nothing due: key %h status %0d",
                           rsp_ch.neighbour_key, rsp_ch.status);
                    errors++;
                end else begin
                    want = graph_results_due.pop_front();
                    if (rsp_ch.neighbour_key !== want.neighbour_key) begin
                        $error("neighbour_key: expected %h, got %h",
                               want.neighbour_key, rsp_ch.neighbour_key);
                        errors++;
                    end
                    if (rsp_ch.is_marked_flag !== want.is_marked_flag) begin
                        $error("is_marked_flag: expected %b, got %b",
                               want.is_marked_flag, rsp_ch.is_marked_flag);
                        errors++;
                    end
                    if (rsp_ch.has_neighbour !== want.has_neighbour) begin
                        $error("has_neighbour: expected %b, got %b",
                               want.has_neighbour, rsp_ch.has_neighbour);
                        errors++;
                    end
                    if (rsp_ch.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                        errors++;
                    end
                    if (rsp_ch.last_result !== want.last_result) begin
                        $error("last_result: expected %b, got %b",
                               want.last_result, rsp_ch.last_result);
                        errors++;
                    end
                end
            end
            // one long hold-off while requests keep coming, otherwise random gaps outside the quiet stretch
            if (stall_left > 0) begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end else if (!stall_done && ops_taken == 100) begin
                stall_done = 1'b1;
                stall_left = 400;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= quiet || ($urandom_range(0, 99) >= 32);
            end
        end
    end

    // stimulus, reset and end of run
    initial begin
        int n_real;
        int r;
        logic [KEY_W-1:0] vkey;
        rst_n  = 1'b0;
        n_real = 0;

        // lookups and a mark clear on an empty table
        queue_op(KIND_LIST, 32'd5, 32'd0, 16'd0);
        queue_op(KIND_MARK, 32'd5, 32'd0, 16'd0);
        queue_op(KIND_IS_MARKED, 32'd5, 32'd0, 16'd0);
        queue_op(KIND_ADD_EDGE, 32'd5, 32'd6, 16'd1);
        queue_op(KIND_CLEAR_MARKS, 32'd0, 32'd0, 16'd0);
        // extreme keys and a duplicate key
        queue_op(KIND_ADD_VERTEX, 32'h0, 32'hffff_ffff, 16'hffff);
        queue_op(KIND_ADD_VERTEX, 32'hffff_ffff, 32'h0, 16'h0);
        queue_op(KIND_ADD_VERTEX, 32'h0, 32'h0, 16'h0);
        queue_op(KIND_LIST, 32'h0, 32'h0, 16'h0);
        // extreme weights, self-edge, zero weight, missing target
        queue_op(KIND_ADD_EDGE, 32'h0, 32'hffff_ffff, 16'h8000);
        queue_op(KIND_ADD_EDGE, 32'h0, 32'h0, 16'h7fff);
        queue_op(KIND_ADD_EDGE, 32'hffff_ffff, 32'h0, 16'h0);
        queue_op(KIND_ADD_EDGE, 32'h0, 32'd12345, 16'd9);
        queue_op(KIND_LIST, 32'h0, 32'h0, 16'h0);
        queue_op(KIND_LIST, 32'hffff_ffff, 32'h0, 16'h0);
        // marks
        queue_op(KIND_MARK, 32'hffff_ffff, 32'h0, 16'h0);
        queue_op(KIND_IS_MARKED, 32'hffff_ffff, 32'h0, 16'h0);
        queue_op(KIND_IS_MARKED, 32'h0, 32'h0, 16'h0);
        // spare codes
        queue_op(KIND_SPARE_A, 32'h0, 32'h0, 16'h0);
        queue_op(KIND_SPARE_B, 32'hffff_ffff, 32'hffff_ffff, 16'hffff);
        // remove the self-edge again
        queue_op(KIND_ADD_EDGE, 32'h0, 32'h0, 16'h0);
        queue_op(KIND_LIST, 32'h0, 32'h0, 16'h0);
        queue_op(KIND_CLEAR_MARKS, 32'h0, 32'h0, 16'h0);
        queue_op(KIND_IS_MARKED, 32'hffff_ffff, 32'h0, 16'h0);

        // random graph traffic
        while (n_real < 300) begin
            r = $urandom_range(0, 99);
            if (r < 9) begin
                r = $urandom_range(0, 99);
                if (r < 75 || gen_keys.size() == 0) vkey = $urandom;
                else if (r < 90) vkey = gen_keys[$urandom_range(0, gen_keys.size() - 1)];
                else vkey = (r < 95) ? 32'h0 : 32'hffff_ffff;
                queue_op(KIND_ADD_VERTEX, vkey, $urandom, WEIGHT_W'($urandom));
                n_real++;
            end else if (r < 44) begin
                vkey = pick_key();
                queue_op(KIND_ADD_EDGE, vkey, pick_key(), rand_weight());
                n_real++;
            end else if (r < 68) begin
                queue_op(KIND_LIST, pick_key(), $urandom, rand_weight());
                n_real++;
            end else if (r < 72) begin
                queue_op(KIND_CLEAR_MARKS, $urandom, $urandom, WEIGHT_W'($urandom));
                n_real++;
            end else if (r < 84) begin
                queue_op(KIND_MARK, pick_key(), $urandom, WEIGHT_W'($urandom));
                n_real++;
            end else if (r < 97) begin
                queue_op(KIND_IS_MARKED, pick_key(), $urandom, WEIGHT_W'($urandom));
                n_real++;
            end else begin
                queue_op(($urandom_range(0, 1) == 0) ? KIND_SPARE_A : KIND_SPARE_B,
                         $urandom, $urandom, WEIGHT_W'($urandom));
            end
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // drain: every request taken and every result back
        do @(negedge clk);
        while (graph_ops_queued.size() != 0 || req_ch.valid || graph_results_due.size() != 0);
        repeat (40) @(posedge clk);

        if (errors == 0) $display("tb_top passed");
        else $display("tb_top failed");
        $finish;
    end

    // run limit
    initial begin
        #1_000_000;
        $display("tb_top failed");
        $finish;
    end

endmodule
